FILE: sv/tfb_pkg.sv
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types and constants for the telemetry frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_HEADER = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST   = 8'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] DEST_RESET   = 8'hFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified payload byte, as handed from the front to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] function_code;
    logic [BYTE_W-1:0] payload_length;
    logic              with_header;
    logic              with_check;
  } tfb_cmd_t;

  // Front to queue.
  typedef struct packed {
    logic     push;
    tfb_cmd_t cmd;
  } tfb_push_t;

  // Queue head as seen by the back.
  typedef struct packed {
    logic     valid;
    tfb_cmd_t cmd;
  } tfb_head_t;

endpackage

FILE: sv/tfb_channels.sv
// ----------------------------------------------------------------------------
// tfb_channels
// Valid/ready channel interfaces for payload input, framed output and the
// configuration write port.
// ----------------------------------------------------------------------------
interface tfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] function_code;
  logic [7:0] payload_length;
  logic       first_of_frame;
  logic       last_of_frame;

  modport source (
    output valid, payload_byte, function_code, payload_length,
           first_of_frame, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, payload_byte, function_code, payload_length,
           first_of_frame, last_of_frame,
    output ready
  );
endinterface

interface tfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_frame;

  modport source (output valid, out_byte, end_of_frame, input ready);
  modport sink (input valid, out_byte, end_of_frame, output ready);
endinterface

interface tfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/tfb_front.sv
// ----------------------------------------------------------------------------
// tfb_front
// Accepts payload bytes and classifies each into a command for the back:
// whether a header precedes it and whether check bytes follow it.
// ----------------------------------------------------------------------------
module tfb_front (
  tfb_in_if.sink          items,
  input  logic            queue_full,
  output tfb_pkg::tfb_push_t push
);
  import tfb_pkg::*;

  assign items.ready = ~queue_full;

  always_comb begin
    push.push               = items.valid & ~queue_full;
    push.cmd.payload_byte   = items.payload_byte;
    push.cmd.function_code  = items.function_code;
    push.cmd.payload_length = items.payload_length;
    push.cmd.with_header    = items.first_of_frame;
    push.cmd.with_check     = items.last_of_frame;
  end

endmodule

FILE: sv/tfb_queue.sv
// ----------------------------------------------------------------------------
// tfb_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module tfb_queue (
  input  logic               clk,
  input  logic               rst,
  input  tfb_pkg::tfb_push_t push,
  input  logic               pop,
  output logic               full,
  output tfb_pkg::tfb_head_t head
);
  import tfb_pkg::*;

  tfb_cmd_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];
  assign do_pop     = pop & head.valid;

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push.push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/tfb_back.sv
// ----------------------------------------------------------------------------
// tfb_back
// Sequences each command into framed bytes, keeps the running sum and sum of
// sums, and holds the result in an output register.
// ----------------------------------------------------------------------------
module tfb_back (
  input  logic               clk,
  input  logic               rst,
  input  tfb_pkg::tfb_head_t head,
  output logic               pop,
  tfb_cfg_if.sink            cfg,
  tfb_out_if.source          frames
);
  import tfb_pkg::*;

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_CODE = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SUM  = 3'd5;
  localparam logic [2:0] PH_SOS  = 3'd6;

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] dest_address;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] running_sum_of_sums;
  logic [2:0]        phase;
  logic              mid;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_frame;

  logic [2:0]        cur_phase;
  logic [2:0]        phase_next;
  logic              mid_next;
  logic              emit;
  logic              checked;
  logic              eof;
  logic [BYTE_W-1:0] sel_byte;
  logic [BYTE_W-1:0] sum_base;
  logic [BYTE_W-1:0] sos_base;
  logic [BYTE_W-1:0] running_sum_next;
  logic [BYTE_W-1:0] running_sum_of_sums_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= HEADER_RESET;
      dest_address <= DEST_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HEADER: header_byte  <= cfg.data;
        REG_DEST:   dest_address <= cfg.data;
        default:    ;
      endcase
    end
  end

  // A fresh head starts at the header or straight at the payload byte.
  assign cur_phase = mid ? phase : (head.cmd.with_header ? PH_HDR : PH_DATA);
  assign emit      = head.valid & (~out_valid | frames.ready);

  always_comb begin
    sel_byte   = head.cmd.payload_byte;
    checked    = 1'b1;
    eof        = 1'b0;
    pop        = 1'b0;
    phase_next = cur_phase;
    mid_next   = 1'b1;
    case (cur_phase)
      PH_HDR: begin
        sel_byte   = header_byte;
        phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        sel_byte   = dest_address;
        phase_next = PH_CODE;
      end
      PH_CODE: begin
        sel_byte   = head.cmd.function_code;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        sel_byte   = head.cmd.payload_length;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        sel_byte = head.cmd.payload_byte;
        if (head.cmd.with_check) begin
          phase_next = PH_SUM;
        end else begin
          pop      = emit;
          mid_next = 1'b0;
        end
      end
      PH_SUM: begin
        sel_byte   = running_sum;
        checked    = 1'b0;
        phase_next = PH_SOS;
      end
      PH_SOS: begin
        sel_byte = running_sum_of_sums;
        checked  = 1'b0;
        eof      = 1'b1;
        pop      = emit;
        mid_next = 1'b0;
      end
      default: begin
        checked  = 1'b0;
        mid_next = 1'b0;
      end
    endcase
  end

  // Clear the checks on the header byte of a new frame.
  assign sum_base                 = (cur_phase == PH_HDR) ? '0 : running_sum;
  assign sos_base                 = (cur_phase == PH_HDR) ? '0 : running_sum_of_sums;
  assign running_sum_next         = sum_base + sel_byte;
  assign running_sum_of_sums_next = sos_base + running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum         <= '0;
      running_sum_of_sums <= '0;
      phase               <= PH_HDR;
      mid                 <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (emit) begin
        phase <= phase_next;
        mid   <= mid_next;
        if (checked) begin
          running_sum         <= running_sum_next;
          running_sum_of_sums <= running_sum_of_sums_next;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (frames.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte     <= sel_byte;
      end_of_frame <= eof;
    end
  end

  assign frames.valid        = out_valid;
  assign frames.out_byte     = out_byte;
  assign frames.end_of_frame = end_of_frame;

endmodule

FILE: sv/telemetry_frame_builder_core.sv
// ----------------------------------------------------------------------------
// telemetry_frame_builder_core
// Frames a payload byte stream with header, address, code, length and two
// check bytes (wrapping sum, then sum of sums).
// ----------------------------------------------------------------------------
// Usage:
//   items  : payload bytes with first/last marks; function_code and
//            payload_length are used only on a first byte.
//   frames : framed output bytes; end_of_frame marks the sum-of-sums byte.
//   cfg    : register writes (index 0 header byte, 1 destination address);
//            always ready, other indexes are ignored.
// A byte is written into the queue when it is transferred and passes the
// output register before it appears on frames. The output sequencer sets
// the rate: it emits one output byte per cycle while frames accepts, a first
// byte adding header, address, code and length and a last byte the two check
// bytes, and a 4-entry queue lets items keep arriving while those bytes drain.
// When frames stalls, the output register holds its byte, the queue fills
// and items.ready drops once it is full.
// Reset clears the queue, the sequencer and both checks, and restores the
// registers to header 0xAA and address 0xFF.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_core (
  input  logic       clk,
  input  logic       rst,
  tfb_in_if.sink     items,
  tfb_out_if.source  frames,
  tfb_cfg_if.sink    cfg
);
  import tfb_pkg::*;

  tfb_push_t push;
  tfb_head_t head;
  logic      queue_full;
  logic      pop;

  tfb_front u_front (
    .items      (items),
    .queue_full (queue_full),
    .push       (push)
  );

  tfb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (queue_full),
    .head (head)
  );

  tfb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .cfg    (cfg),
    .frames (frames)
  );

endmodule
